// File: sv/tbhbm_pkg.sv
package tbhbm_pkg;

    localparam logic [2:0]  PAIRS_PER_BYTE = 3'd4;
    localparam logic [15:0] SETTLE_RESET   = 16'd20000;

    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_EXIT    = 3'd2;
    localparam logic [2:0] CMD_SEND    = 3'd3;
    localparam logic [2:0] CMD_RECEIVE = 3'd4;
    localparam logic [2:0] CMD_CHECK   = 3'd5;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_STARTW = 4'd1,
        PH_SETTLE = 4'd2,
        PH_SEND_A = 4'd3,
        PH_SEND_B = 4'd4,
        PH_RECV_A = 4'd5,
        PH_RECV_B = 4'd6,
        PH_CHK_A  = 4'd7,
        PH_CHK_B  = 4'd8
    } phase_t;

endpackage

// File: sv/tbhbm_cmd_if.sv
interface tbhbm_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic       write_mode;
    logic [7:0] send_value;
    logic       clock_line_low;
    logic       data_line_low;

    modport source (output valid, output command, output write_mode, output send_value,
                    output clock_line_low, output data_line_low, input ready);
    modport sink (input valid, input command, input write_mode, input send_value,
                  input clock_line_low, input data_line_low, output ready);
endinterface

// File: sv/tbhbm_res_if.sv
interface tbhbm_res_if;
    logic       valid;
    logic       ready;
    logic       atn_pull;
    logic       data_pull;
    logic       clock_pull;
    logic       busy_res;
    logic       done_res;
    logic [7:0] received_value;
    logic       status_error;

    modport source (output valid, output atn_pull, output data_pull, output clock_pull,
                    output busy_res, output done_res, output received_value,
                    output status_error, input ready);
    modport sink (input valid, input atn_pull, input data_pull, input clock_pull,
                  input busy_res, input done_res, input received_value,
                  input status_error, output ready);
endinterface

// File: sv/tbhbm_cfg_if.sv
interface tbhbm_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] settle_ticks;

    modport source (output valid, output settle_ticks, input ready);
    modport sink (input valid, input settle_ticks, output ready);
endinterface

// File: sv/two_bit_handshake_bus_master_core.sv
// Channel   Modport   Word carried
// cmd       sink      command, write_mode, send_value, clock_line_low, data_line_low
// res       source    atn_pull, data_pull, clock_pull, busy_res, done_res,
//                     received_value, status_error
// cfg       sink      settle_ticks (always ready)
//
// Each accepted word is one line tick and yields exactly one result word.
// Each word passes through an input register, then the phase logic feeding the result register.
// A new word is accepted every cycle while the result side keeps up.
// rst_n clears the phase, the line pulls and the latches, and loads settle_ticks with 20000.
// When res is stalled the result register holds and the input register fills, then cmd stalls.
module two_bit_handshake_bus_master_core (
    input  logic           clk,
    input  logic           rst_n,
    tbhbm_cmd_if.sink      cmd,
    tbhbm_res_if.source    res,
    tbhbm_cfg_if.sink      cfg
);

    // Input register
    logic       in_valid_reg;
    logic [2:0] command_reg;
    logic       write_mode_reg;
    logic [7:0] send_value_reg;
    logic       clk_low_reg;
    logic       dat_low_reg;

    // Block state
    logic [15:0]          settle_ticks_reg;
    tbhbm_pkg::phase_t    phase_reg, phase_next;
    logic [7:0]           shift_reg, shift_next;
    logic [2:0]           pair_reg, pair_next;
    logic [15:0]          settle_cnt_reg, settle_cnt_next;
    logic                 atn_reg, atn_next;
    logic                 data_reg, data_next;
    logic                 clock_reg, clock_next;
    logic                 dir_reg, dir_next;
    logic                 err_reg, err_next;
    logic [7:0]           rx_reg, rx_next;
    logic                 done_next;
    logic [2:0]           pair_dec;

    // Result register
    logic       out_valid_reg;
    logic       atn_out_reg;
    logic       data_out_reg;
    logic       clock_out_reg;
    logic       busy_out_reg;
    logic       done_out_reg;
    logic [7:0] rx_out_reg;
    logic       err_out_reg;

    logic advance;

    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;
    assign pair_dec  = pair_reg - 3'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        shift_next      = shift_reg;
        pair_next       = pair_reg;
        settle_cnt_next = settle_cnt_reg;
        atn_next        = atn_reg;
        data_next       = data_reg;
        clock_next      = clock_reg;
        dir_next        = dir_reg;
        err_next        = err_reg;
        rx_next         = rx_reg;
        done_next       = 1'b0;
        case (phase_reg)
            tbhbm_pkg::PH_IDLE:
            begin
                case (command_reg)
                    tbhbm_pkg::CMD_START:
                    begin
                        clock_next = 1'b0;
                        phase_next = tbhbm_pkg::PH_STARTW;
                    end
                    tbhbm_pkg::CMD_EXIT:
                    begin
                        atn_next        = 1'b0;
                        data_next       = 1'b0;
                        clock_next      = 1'b1;
                        settle_cnt_next = settle_ticks_reg;
                        phase_next      = tbhbm_pkg::PH_SETTLE;
                    end
                    tbhbm_pkg::CMD_SEND:
                    begin
                        data_next  = send_value_reg[0];
                        shift_next = {1'b0, send_value_reg[7:1]};
                        pair_next  = tbhbm_pkg::PAIRS_PER_BYTE;
                        atn_next   = 1'b0;
                        phase_next = tbhbm_pkg::PH_SEND_A;
                    end
                    tbhbm_pkg::CMD_RECEIVE:
                    begin
                        shift_next = 8'd0;
                        pair_next  = tbhbm_pkg::PAIRS_PER_BYTE;
                        phase_next = tbhbm_pkg::PH_RECV_A;
                    end
                    tbhbm_pkg::CMD_CHECK:
                    begin
                        dir_next   = write_mode_reg;
                        atn_next   = 1'b0;
                        phase_next = tbhbm_pkg::PH_CHK_A;
                    end
                    default:
                    begin
                        phase_next = tbhbm_pkg::PH_IDLE;
                    end
                endcase
            end
            tbhbm_pkg::PH_STARTW:
            begin
                if (clk_low_reg)
                begin
                    atn_next        = 1'b1;
                    settle_cnt_next = settle_ticks_reg;
                    phase_next      = tbhbm_pkg::PH_SETTLE;
                end
            end
            tbhbm_pkg::PH_SETTLE:
            begin
                if (settle_cnt_reg == 16'd0)
                begin
                    done_next  = 1'b1;
                    phase_next = tbhbm_pkg::PH_IDLE;
                end
                else
                begin
                    settle_cnt_next = settle_cnt_reg - 16'd1;
                end
            end
            tbhbm_pkg::PH_SEND_A:
            begin
                if (!clk_low_reg)
                begin
                    data_next  = shift_reg[0];
                    shift_next = {1'b0, shift_reg[7:1]};
                    atn_next   = 1'b1;
                    phase_next = tbhbm_pkg::PH_SEND_B;
                end
            end
            tbhbm_pkg::PH_SEND_B:
            begin
                if (clk_low_reg)
                begin
                    pair_next = pair_dec;
                    if (pair_dec == 3'd0)
                    begin
                        data_next  = 1'b0;
                        done_next  = 1'b1;
                        phase_next = tbhbm_pkg::PH_IDLE;
                    end
                    else
                    begin
                        data_next  = shift_reg[0];
                        shift_next = {1'b0, shift_reg[7:1]};
                        atn_next   = 1'b0;
                        phase_next = tbhbm_pkg::PH_SEND_A;
                    end
                end
            end
            tbhbm_pkg::PH_RECV_A:
            begin
                if (!clk_low_reg)
                begin
                    shift_next = {dat_low_reg, shift_reg[7:1]};
                    atn_next   = 1'b0;
                    phase_next = tbhbm_pkg::PH_RECV_B;
                end
            end
            tbhbm_pkg::PH_RECV_B:
            begin
                if (clk_low_reg)
                begin
                    shift_next = {dat_low_reg, shift_reg[7:1]};
                    atn_next   = 1'b1;
                    pair_next  = pair_dec;
                    if (pair_dec == 3'd0)
                    begin
                        rx_next    = {dat_low_reg, shift_reg[7:1]};
                        done_next  = 1'b1;
                        phase_next = tbhbm_pkg::PH_IDLE;
                    end
                    else
                    begin
                        phase_next = tbhbm_pkg::PH_RECV_A;
                    end
                end
            end
            tbhbm_pkg::PH_CHK_A:
            begin
                if (!clk_low_reg)
                begin
                    // A released data line here means the partner did not acknowledge.
                    if (!dat_low_reg)
                    begin
                        err_next   = 1'b1;
                        done_next  = 1'b1;
                        phase_next = tbhbm_pkg::PH_IDLE;
                    end
                    else
                    begin
                        err_next   = 1'b0;
                        data_next  = 1'b1;
                        atn_next   = 1'b1;
                        phase_next = tbhbm_pkg::PH_CHK_B;
                    end
                end
            end
            tbhbm_pkg::PH_CHK_B:
            begin
                if (clk_low_reg)
                begin
                    if (!dir_reg)
                    begin
                        data_next = 1'b0;
                    end
                    done_next  = 1'b1;
                    phase_next = tbhbm_pkg::PH_IDLE;
                end
            end
            default:
            begin
                phase_next = tbhbm_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            settle_ticks_reg <= tbhbm_pkg::SETTLE_RESET;
            phase_reg        <= tbhbm_pkg::PH_IDLE;
            shift_reg        <= 8'd0;
            pair_reg         <= 3'd0;
            settle_cnt_reg   <= 16'd0;
            atn_reg          <= 1'b0;
            data_reg         <= 1'b0;
            clock_reg        <= 1'b0;
            dir_reg          <= 1'b0;
            err_reg          <= 1'b0;
            rx_reg           <= 8'd0;
        end
        else
        begin
            if (cfg.valid)
            begin
                settle_ticks_reg <= cfg.settle_ticks;
            end
            if (cmd.ready)
            begin
                in_valid_reg <= cmd.valid;
            end
            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                phase_reg      <= phase_next;
                shift_reg      <= shift_next;
                pair_reg       <= pair_next;
                settle_cnt_reg <= settle_cnt_next;
                atn_reg        <= atn_next;
                data_reg       <= data_next;
                clock_reg      <= clock_next;
                dir_reg        <= dir_next;
                err_reg        <= err_next;
                rx_reg         <= rx_next;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            command_reg    <= cmd.command;
            write_mode_reg <= cmd.write_mode;
            send_value_reg <= cmd.send_value;
            clk_low_reg    <= cmd.clock_line_low;
            dat_low_reg    <= cmd.data_line_low;
        end
        if (advance)
        begin
            atn_out_reg   <= atn_next;
            data_out_reg  <= data_next;
            clock_out_reg <= clock_next;
            busy_out_reg  <= (phase_next != tbhbm_pkg::PH_IDLE);
            done_out_reg  <= done_next;
            rx_out_reg    <= rx_next;
            err_out_reg   <= err_next;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.atn_pull       = atn_out_reg;
    assign res.data_pull      = data_out_reg;
    assign res.clock_pull     = clock_out_reg;
    assign res.busy_res       = busy_out_reg;
    assign res.done_res       = done_out_reg;
    assign res.received_value = rx_out_reg;
    assign res.status_error   = err_out_reg;

endmodule
